>>> design/rbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp_pkg: shared types and constants for the random byte pool
// Item kinds, field widths, sequencer states and helper functions.
// ----------------------------------------------------------------------------
package rbp_pkg;

    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int BITS_W   = 6;
    localparam int NEED_W   = 3;
    localparam int IDX_W    = 2;
    localparam int MAX_BITS = 32;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXTRACT,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        EX_IDLE,
        EX_ISSUE,
        EX_CAPTURE,
        EX_MASK
    } ex_state_t;

    typedef struct packed {
        logic              start;
        logic [BITS_W-1:0] bits;
    } ex_cmd_t;

    typedef struct packed {
        logic rd_en;
        logic done;
    } ex_status_t;

    // requests above 32 bits are served as 32
    function automatic logic [BITS_W-1:0] clamp_bits(input logic [BITS_W-1:0] bits);
        if (bits > BITS_W'(MAX_BITS)) begin
            return BITS_W'(MAX_BITS);
        end
        return bits;
    endfunction

    // ceil(bits / 8), valid for clamped counts only
    function automatic logic [NEED_W-1:0] need_bytes(input logic [BITS_W-1:0] bits);
        logic [BITS_W:0] sum;
        sum = {1'b0, bits} + (BITS_W + 1)'(BYTE_W - 1);
        return sum[NEED_W+2:3];
    endfunction

endpackage

>>> design/rbp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/rbp_extract.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp_extract: byte assembler for bit requests
// Issues and captures each pool byte, packs it little-endian, then masks.
// ----------------------------------------------------------------------------
module rbp_extract (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rbp_pkg::ex_cmd_t            cmd,
    input  logic [rbp_pkg::BYTE_W-1:0]  rd_data,
    output rbp_pkg::ex_status_t         status,
    output logic [rbp_pkg::VALUE_W-1:0] value
);

    rbp_pkg::ex_state_t state_reg, state_next;
    logic [rbp_pkg::BITS_W-1:0]  bits_reg, bits_next;
    logic [rbp_pkg::NEED_W-1:0]  need_reg, need_next;
    logic [rbp_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [rbp_pkg::VALUE_W-1:0] acc_reg, acc_next;
    logic [rbp_pkg::VALUE_W:0]   mask_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rbp_pkg::EX_IDLE;
        end else begin
            state_reg <= state_next;
        end
        bits_reg <= bits_next;
        need_reg <= need_next;
        idx_reg  <= idx_next;
        acc_reg  <= acc_next;
    end

    always_comb begin
        state_next = state_reg;
        bits_next  = bits_reg;
        need_next  = need_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        status     = '0;
        unique case (state_reg)
            rbp_pkg::EX_IDLE: begin
                if (cmd.start) begin
                    bits_next  = cmd.bits;
                    need_next  = rbp_pkg::need_bytes(cmd.bits);
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = rbp_pkg::EX_ISSUE;
                end
            end
            rbp_pkg::EX_ISSUE: begin
                status.rd_en = 1'b1;
                state_next   = rbp_pkg::EX_CAPTURE;
            end
            rbp_pkg::EX_CAPTURE: begin
                acc_next[{idx_reg, 3'b000} +: rbp_pkg::BYTE_W] = rd_data;
                if (rbp_pkg::NEED_W'(idx_reg) + rbp_pkg::NEED_W'(1) == need_reg) begin
                    state_next = rbp_pkg::EX_MASK;
                end else begin
                    idx_next   = idx_reg + rbp_pkg::IDX_W'(1);
                    state_next = rbp_pkg::EX_ISSUE;
                end
            end
            rbp_pkg::EX_MASK: begin
                status.done = 1'b1;
                state_next  = rbp_pkg::EX_IDLE;
            end
            default: begin
                state_next = rbp_pkg::EX_IDLE;
            end
        endcase
    end

    // 33-bit form gives all ones for a full 32-bit request
    assign mask_wide = ((rbp_pkg::VALUE_W + 1)'(1) << bits_reg) - (rbp_pkg::VALUE_W + 1)'(1);
    assign value     = acc_reg & mask_wide[rbp_pkg::VALUE_W-1:0];

endmodule

>>> design/random_byte_pool_extractor.sv
// Flow: an item that takes no bytes goes from acceptance through the result state
//   into the output register; a request served from n pool bytes first runs the
//   byte assembler, which issues and captures each byte on the pool RAM's single
//   read port, then masks. Items are accepted only when idle, so one at a time.
// Reset (synchronous, active low): pool empty, pointers zero, no request held,
//   source enabled, output empty. The pool RAM itself is not cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_byte_pool_extractor: ring pool of entropy bytes with bit requests
// Stores incoming bytes in a ring RAM and answers requests of up to 32 bits,
// holding one short request until enough bytes have arrived.
// ----------------------------------------------------------------------------
module random_byte_pool_extractor #(
    parameter int POOL_DEPTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input requests
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [rbp_pkg::BYTE_W-1:0]  s_random_byte,
    input  logic [rbp_pkg::BITS_W-1:0]  s_request_bits,
    // results
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_value_valid,
    output logic [rbp_pkg::VALUE_W-1:0] m_random_value,
    output logic                        m_source_run,
    output logic                        m_byte_dropped
);

    localparam int PTR_W = $clog2(POOL_DEPTH);
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);

    // sequencer and pool state
    rbp_pkg::state_t state_reg, state_next;
    logic [PTR_W-1:0]           wp_reg, wp_next;
    logic [PTR_W-1:0]           rp_reg, rp_next;
    logic [CNT_W-1:0]           fill_reg, fill_next;
    logic                       waiting_reg, waiting_next;
    logic [rbp_pkg::BITS_W-1:0] wbits_reg, wbits_next;
    logic                       src_reg, src_next;

    // result being built for the current request
    logic                        res_valid_reg, res_valid_next;
    logic [rbp_pkg::VALUE_W-1:0] res_value_reg, res_value_next;
    logic                        res_dropped_reg, res_dropped_next;

    // output register
    logic                        m_valid_reg, m_valid_next;
    logic                        m_value_valid_reg, m_value_valid_next;
    logic [rbp_pkg::VALUE_W-1:0] m_random_value_reg, m_random_value_next;
    logic                        m_source_run_reg, m_source_run_next;
    logic                        m_byte_dropped_reg, m_byte_dropped_next;

    // helpers
    logic                        accept;
    logic [PTR_W-1:0]            wp_inc, rp_inc;
    logic [CNT_W-1:0]            fill_inc;
    logic [rbp_pkg::BITS_W-1:0]  req_bits;
    logic [rbp_pkg::NEED_W-1:0]  need_req, need_wait;
    logic                        ram_wr_en;
    logic [rbp_pkg::BYTE_W-1:0]  ram_rd_data;
    rbp_pkg::ex_cmd_t            ex_cmd;
    rbp_pkg::ex_status_t         ex_status;
    logic [rbp_pkg::VALUE_W-1:0] ex_value;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == rbp_pkg::ST_IDLE);

    // ring pointers wrap at the pool depth, which need not be a power of two
    assign wp_inc    = (wp_reg == PTR_W'(POOL_DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
    assign rp_inc    = (rp_reg == PTR_W'(POOL_DEPTH - 1)) ? '0 : rp_reg + PTR_W'(1);
    assign fill_inc  = fill_reg + CNT_W'(1);
    assign req_bits  = rbp_pkg::clamp_bits(s_request_bits);
    assign need_req  = rbp_pkg::need_bytes(req_bits);
    assign need_wait = rbp_pkg::need_bytes(wbits_reg);

    rbp_ram #(
        .WIDTH (rbp_pkg::BYTE_W),
        .DEPTH (POOL_DEPTH)
    ) u_pool (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (s_random_byte),
        .rd_en   (ex_status.rd_en),
        .rd_addr (rp_reg),
        .rd_data (ram_rd_data)
    );

    rbp_extract u_extract (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ex_cmd),
        .rd_data (ram_rd_data),
        .status  (ex_status),
        .value   (ex_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rbp_pkg::ST_IDLE;
            wp_reg      <= '0;
            rp_reg      <= '0;
            fill_reg    <= '0;
            waiting_reg <= 1'b0;
            wbits_reg   <= '0;
            src_reg     <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            fill_reg    <= fill_next;
            waiting_reg <= waiting_next;
            wbits_reg   <= wbits_next;
            src_reg     <= src_next;
            m_valid_reg <= m_valid_next;
        end
        res_valid_reg      <= res_valid_next;
        res_value_reg      <= res_value_next;
        res_dropped_reg    <= res_dropped_next;
        m_value_valid_reg  <= m_value_valid_next;
        m_random_value_reg <= m_random_value_next;
        m_source_run_reg   <= m_source_run_next;
        m_byte_dropped_reg <= m_byte_dropped_next;
    end

    always_comb begin
        state_next          = state_reg;
        wp_next             = wp_reg;
        rp_next             = rp_reg;
        fill_next           = fill_reg;
        waiting_next        = waiting_reg;
        wbits_next          = wbits_reg;
        src_next            = src_reg;
        res_valid_next      = res_valid_reg;
        res_value_next      = res_value_reg;
        res_dropped_next    = res_dropped_reg;
        m_valid_next        = m_valid_reg;
        m_value_valid_next  = m_value_valid_reg;
        m_random_value_next = m_random_value_reg;
        m_source_run_next   = m_source_run_reg;
        m_byte_dropped_next = m_byte_dropped_reg;
        ram_wr_en           = 1'b0;
        ex_cmd              = '0;

        // output register drains independently of the sequencer
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            rbp_pkg::ST_IDLE: begin
                if (accept) begin
                    res_valid_next   = 1'b0;
                    res_value_next   = '0;
                    res_dropped_next = 1'b0;
                    state_next       = rbp_pkg::ST_RESULT;
                    if (s_kind == rbp_pkg::KIND_BYTE) begin
                        if (fill_reg == CNT_W'(POOL_DEPTH)) begin
                            // full pool: byte lost, nothing else moves
                            res_dropped_next = 1'b1;
                        end else begin
                            ram_wr_en = 1'b1;
                            wp_next   = wp_inc;
                            fill_next = fill_inc;
                            if (fill_inc == CNT_W'(POOL_DEPTH)) begin
                                src_next = 1'b0;
                            end
                            // this byte may complete the held request
                            if (waiting_reg && fill_inc >= CNT_W'(need_wait)) begin
                                ex_cmd.start   = 1'b1;
                                ex_cmd.bits    = wbits_reg;
                                fill_next      = fill_inc - CNT_W'(need_wait);
                                src_next       = 1'b1;
                                waiting_next   = 1'b0;
                                wbits_next     = '0;
                                res_valid_next = 1'b1;
                                state_next     = rbp_pkg::ST_EXTRACT;
                            end
                        end
                    end else if (!waiting_reg) begin
                        if (s_request_bits == '0) begin
                            // zero-bit request answers at once with zero
                            res_valid_next = 1'b1;
                        end else if (fill_reg >= CNT_W'(need_req)) begin
                            ex_cmd.start   = 1'b1;
                            ex_cmd.bits    = req_bits;
                            fill_next      = fill_reg - CNT_W'(need_req);
                            src_next       = 1'b1;
                            res_valid_next = 1'b1;
                            state_next     = rbp_pkg::ST_EXTRACT;
                        end else begin
                            // short pool: hold the request, keep the source running
                            waiting_next = 1'b1;
                            wbits_next   = req_bits;
                            src_next     = 1'b1;
                        end
                    end
                    // a request while one is held falls through with an empty result
                end
            end
            rbp_pkg::ST_EXTRACT: begin
                if (ex_status.rd_en) begin
                    rp_next = rp_inc;
                end
                if (ex_status.done) begin
                    res_value_next = ex_value;
                    state_next     = rbp_pkg::ST_RESULT;
                end
            end
            rbp_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_value_valid_next  = res_valid_reg;
                    m_random_value_next = res_value_reg;
                    m_source_run_next   = src_reg;
                    m_byte_dropped_next = res_dropped_reg;
                    state_next          = rbp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rbp_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_value_valid  = m_value_valid_reg;
    assign m_random_value = m_random_value_reg;
    assign m_source_run   = m_source_run_reg;
    assign m_byte_dropped = m_byte_dropped_reg;

endmodule
